// File: src/vertex_rotate_project_viewport_defines.svh
// assertion macros for the vertex rotate, project and viewport block
`ifndef VERTEX_ROTATE_PROJECT_VIEWPORT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_VIEWPORT_DEFINES_SVH

// same-cycle implication
`define VRPV_ASSERT_HOLDS(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vrpv: same-cycle check failed");

// next-cycle implication
`define VRPV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vrpv: next-cycle check failed");

// condition on the cycle after reset
`define VRPV_ASSERT_AFTER_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("vrpv: post-reset check failed");

`endif

// File: src/vrpv_pkg.sv
// package: register map, field widths and reset values of the vertex transform
package vrpv_pkg;

  localparam int CFG_DATA_WIDTH  = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int ANGLE_WIDTH     = 16;
  localparam int ANGLE_FRAC      = 14;
  localparam int SIZE_WIDTH      = 12;
  localparam int PIX_WIDTH       = 16;
  localparam int QUO_BITS        = PIX_WIDTH;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_COS_ANGLE     = 2'd0,
    REG_SIN_ANGLE     = 2'd1,
    REG_SCREEN_WIDTH  = 2'd2,
    REG_SCREEN_HEIGHT = 2'd3
  } cfg_reg_t;

  localparam logic signed [ANGLE_WIDTH-1:0] COS_RESET    = 16'sd15137;
  localparam logic signed [ANGLE_WIDTH-1:0] SIN_RESET    = 16'sd6270;
  localparam logic        [SIZE_WIDTH-1:0]  WIDTH_RESET  = 12'd800;
  localparam logic        [SIZE_WIDTH-1:0]  HEIGHT_RESET = 12'd600;

  localparam logic signed [PIX_WIDTH-1:0] PIX_MAX  = 16'sh7FFF;
  localparam logic signed [PIX_WIDTH-1:0] PIX_MIN  = 16'sh8000;
  localparam logic signed [PIX_WIDTH-1:0] PIX_ZERO = 16'sh0000;

endpackage

// File: src/vertex_rotate_project_viewport.sv
// top level: y-axis rotation, perspective divide and viewport mapping of vertices
//
// channel   signals                              direction
// config    cfg_write cfg_index cfg_data          in
// vertex    in_valid in_ready vert_x vert_y vert_z in
// pixel     out_valid out_ready pix_x pix_y behind_eye out
//
// one request per clock while in_ready is high
// the depth is set by the 16-stage restoring divider, one quotient bit per stage
// rst is synchronous; it empties the pipeline and loads the reset register values
// a held result stalls every stage at once; in_ready is low only while out_valid
// is high and out_ready is low
`include "vertex_rotate_project_viewport_defines.svh"

module vertex_rotate_project_viewport #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write,
  input  logic [vrpv_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [vrpv_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [COORD_WIDTH-1:0]            vert_x,
  input  logic signed [COORD_WIDTH-1:0]            vert_y,
  input  logic signed [COORD_WIDTH-1:0]            vert_z,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [vrpv_pkg::PIX_WIDTH-1:0]    pix_x,
  output logic signed [vrpv_pkg::PIX_WIDTH-1:0]    pix_y,
  output logic                                     behind_eye
);

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = vrpv_pkg::ANGLE_WIDTH;
  localparam int PW   = CW + AW;
  localparam int RW   = PW + 1;
  localparam int SW   = RW + 1;
  localparam int MW   = SW + vrpv_pkg::SIZE_WIDTH + 1;
  localparam int NW   = MW + 3;
  localparam int QB   = vrpv_pkg::QUO_BITS;
  localparam int NSTG = 7 + QB;

  typedef struct packed {
    logic                 behind;
    logic                 neg_x;
    logic                 big_x;
    logic                 neg_y;
    logic                 big_y;
    logic signed [NW-1:0] dvs;
    logic signed [NW-1:0] rem_x;
    logic signed [NW-1:0] rem_y;
    logic [QB-1:0]        q_x;
    logic [QB-1:0]        q_y;
  } div_stage_t;

  logic signed [AW-1:0]                     cos_angle;
  logic signed [AW-1:0]                     sin_angle;
  logic [vrpv_pkg::SIZE_WIDTH-1:0]          screen_width;
  logic [vrpv_pkg::SIZE_WIDTH-1:0]          screen_height;

  logic                                     advance;
  logic [NSTG-1:0]                          stage_valid;

  logic signed [CW-1:0] x0, y0, z0;
  logic signed [PW-1:0] xc, zs, xs, zc;
  logic signed [CW-1:0] y1;
  logic signed [RW-1:0] xr, yr, zr;
  logic signed [SW-1:0] sum_x, sum_y, dvs3;
  logic                 behind3;
  logic signed [MW-1:0] nx, ny;
  logic signed [SW-1:0] dvs4;
  logic                 behind4;
  logic signed [NW-1:0] npx, npy, dvs5;
  logic                 behind5;
  div_stage_t           dst [0:QB];
  div_stage_t           dst_next [0:QB];

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_angle     <= vrpv_pkg::COS_RESET;
      sin_angle     <= vrpv_pkg::SIN_RESET;
      screen_width  <= vrpv_pkg::WIDTH_RESET;
      screen_height <= vrpv_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (vrpv_pkg::cfg_reg_t'(cfg_index))
        vrpv_pkg::REG_COS_ANGLE:     cos_angle     <= $signed(cfg_data[AW-1:0]);
        vrpv_pkg::REG_SIN_ANGLE:     sin_angle     <= $signed(cfg_data[AW-1:0]);
        vrpv_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data[vrpv_pkg::SIZE_WIDTH-1:0];
        vrpv_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[vrpv_pkg::SIZE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      out_valid   <= 1'b0;
    end else if (advance) begin
      stage_valid <= {stage_valid[NSTG-2:0], in_valid};
      out_valid   <= stage_valid[NSTG-1];
    end
  end

  // rotate, sum, scale, offset
  always_ff @(posedge clk) begin
    if (advance) begin
      x0 <= vert_x;
      y0 <= vert_y;
      z0 <= vert_z;

      xc <= PW'(x0) * PW'(cos_angle);
      zs <= PW'(z0) * PW'(sin_angle);
      xs <= PW'(x0) * PW'(sin_angle);
      zc <= PW'(z0) * PW'(cos_angle);
      y1 <= y0;

      xr <= RW'(xc) - RW'(zs);
      zr <= RW'(xs) + RW'(zc);
      yr <= RW'(y1) <<< vrpv_pkg::ANGLE_FRAC;

      sum_x   <= SW'(xr) + SW'(zr);
      sum_y   <= SW'(yr) + SW'(zr);
      dvs3    <= SW'(zr) <<< 1;
      behind3 <= zr[RW-1] || (zr == '0);

      nx      <= MW'(sum_x) * MW'($signed({1'b0, screen_width}));
      ny      <= MW'(sum_y) * MW'($signed({1'b0, screen_height}));
      dvs4    <= dvs3;
      behind4 <= behind3;

      // bias by half the output range so the quotient is unsigned
      npx     <= NW'(nx) + (NW'(dvs4) <<< (QB - 1));
      npy     <= NW'(ny) + (NW'(dvs4) <<< (QB - 1));
      dvs5    <= NW'(dvs4);
      behind5 <= behind4;
    end
  end

  // range check, then restoring divider, msb first
  always_comb begin
    logic signed [NW-1:0] shifted;
    logic                 ge_x;
    logic                 ge_y;
    dst_next[0].behind = behind5;
    dst_next[0].neg_x  = npx[NW-1];
    dst_next[0].big_x  = npx >= (dvs5 <<< QB);
    dst_next[0].neg_y  = npy[NW-1];
    dst_next[0].big_y  = npy >= (dvs5 <<< QB);
    dst_next[0].dvs    = dvs5;
    dst_next[0].rem_x  = npx;
    dst_next[0].rem_y  = npy;
    dst_next[0].q_x    = '0;
    dst_next[0].q_y    = '0;
    for (int k = 1; k <= QB; k++) begin
      shifted           = dst[k-1].dvs <<< (QB - k);
      ge_x              = dst[k-1].rem_x >= shifted;
      ge_y              = dst[k-1].rem_y >= shifted;
      dst_next[k]       = dst[k-1];
      dst_next[k].rem_x = ge_x ? dst[k-1].rem_x - shifted : dst[k-1].rem_x;
      dst_next[k].rem_y = ge_y ? dst[k-1].rem_y - shifted : dst[k-1].rem_y;
      dst_next[k].q_x   = {dst[k-1].q_x[QB-2:0], ge_x};
      dst_next[k].q_y   = {dst[k-1].q_y[QB-2:0], ge_y};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k <= QB; k++) begin
        dst[k] <= dst_next[k];
      end
    end
  end

  // zero when behind the eye, else saturate and remove bias
  always_ff @(posedge clk) begin
    if (advance) begin
      behind_eye <= dst[QB].behind;
      if (dst[QB].behind) begin
        pix_x <= vrpv_pkg::PIX_ZERO;
        pix_y <= vrpv_pkg::PIX_ZERO;
      end else begin
        if (dst[QB].neg_x) begin
          pix_x <= vrpv_pkg::PIX_MIN;
        end else if (dst[QB].big_x) begin
          pix_x <= vrpv_pkg::PIX_MAX;
        end else begin
          pix_x <= $signed({~dst[QB].q_x[QB-1], dst[QB].q_x[QB-2:0]});
        end
        if (dst[QB].neg_y) begin
          pix_y <= vrpv_pkg::PIX_MIN;
        end else if (dst[QB].big_y) begin
          pix_y <= vrpv_pkg::PIX_MAX;
        end else begin
          pix_y <= $signed({~dst[QB].q_y[QB-1], dst[QB].q_y[QB-2:0]});
        end
      end
    end
  end

  `VRPV_ASSERT_HOLDS(a_behind_gives_zero, clk, rst, out_valid && behind_eye, pix_x == '0 && pix_y == '0)
  `VRPV_ASSERT_NEXT(a_stall_freezes_pipe, clk, rst, !in_ready, $stable(stage_valid) && out_valid)
  `VRPV_ASSERT_AFTER_RESET(a_reset_empties_pipe, clk, rst, !out_valid && stage_valid == '0)

endmodule
